FILE: sv/ucs_pkg.sv
`default_nettype none
package ucs_pkg;

    localparam int unsigned MAX_DIM_DEF = 8192;

    localparam int unsigned PW = 29;
    localparam int unsigned LANES = 4;

    typedef enum logic [2:0] {
        CFG_CROP_LEFT = 3'd0,
        CFG_CROP_TOP  = 3'd1,
        CFG_CROP_COLS = 3'd2,
        CFG_CROP_ROWS = 3'd3,
        CFG_OUT_COLS  = 3'd4,
        CFG_OUT_ROWS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0] rect_left;
        logic [12:0] rect_top;
        logic [13:0] rect_cols;
        logic [13:0] rect_rows;
    } t_in_item;

    typedef struct packed {
        logic [13:0] out_left;
        logic [13:0] out_top;
        logic [13:0] out_width;
        logic [13:0] out_height;
    } t_out_item;

    typedef struct packed {
        logic [12:0] cl;
        logic [12:0] ct;
        logic [13:0] cc;
        logic [13:0] cr;
        logic [13:0] sw;
        logic [13:0] sh;
        logic        scaled;
    } t_dims;

    typedef struct packed {
        logic                       valid;
        logic                       zero;
        logic [LANES-1:0][PW-1:0]   num;
    } t_prod;

    typedef struct packed {
        logic                       valid;
        logic                       zero;
        logic [LANES-1:0][13:0]     rem;
        logic [LANES-1:0][PW-1:0]   num;
        logic [LANES-1:0][PW-1:0]   quo;
    } t_div_st;

    typedef struct packed {
        logic                       valid;
        logic                       zero;
        logic [LANES-1:0][PW-1:0]   quo;
    } t_quo;

endpackage
`default_nettype wire

FILE: sv/ucs_front.sv
`default_nettype none
module ucs_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire ucs_pkg::t_in_item i_item,
    input  wire ucs_pkg::t_dims  i_dims,
    output ucs_pkg::t_prod       o_prod
);

    logic        r_a_valid, r_a_zero;
    logic [13:0] r_a_x, r_a_y, r_a_w, r_a_h;
    logic        n_a_zero;
    logic [13:0] n_a_x, n_a_y, n_a_w, n_a_h;
    logic [14:0] hend, vend;
    ucs_pkg::t_prod r_b, n_b;
    logic [27:0] px, py, pw, ph;

    always_comb begin
        hend = {2'b0, i_item.rect_left} + {1'b0, i_item.rect_cols};
        vend = {2'b0, i_item.rect_top} + {1'b0, i_item.rect_rows};
        n_a_zero = (i_dims.cc == 14'd0) || (i_dims.cr == 14'd0)
            || (hend < {2'b0, i_dims.cl})
            || ({2'b0, i_item.rect_left} > ({2'b0, i_dims.cl} + {1'b0, i_dims.cc}))
            || (vend < {2'b0, i_dims.ct})
            || ({2'b0, i_item.rect_top} > ({2'b0, i_dims.ct} + {1'b0, i_dims.cr}));
        if (i_item.rect_left < i_dims.cl) begin
            n_a_x = 14'd0;
            n_a_w = 14'(hend - {2'b0, i_dims.cl});
        end else begin
            n_a_x = {1'b0, i_item.rect_left - i_dims.cl};
            n_a_w = i_item.rect_cols;
        end
        if (i_item.rect_top < i_dims.ct) begin
            n_a_y = 14'd0;
            n_a_h = 14'(vend - {2'b0, i_dims.ct});
        end else begin
            n_a_y = {1'b0, i_item.rect_top - i_dims.ct};
            n_a_h = i_item.rect_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= n_a_zero;
            r_a_x    <= n_a_x;
            r_a_y    <= n_a_y;
            r_a_w    <= n_a_w;
            r_a_h    <= n_a_h;
        end
    end

    always_comb begin
        px = {14'd0, r_a_x} * {14'd0, i_dims.sw};
        py = {14'd0, r_a_y} * {14'd0, i_dims.sh};
        pw = {14'd0, r_a_w} * {14'd0, i_dims.sw};
        ph = {14'd0, r_a_h} * {14'd0, i_dims.sh};
        n_b.valid  = r_a_valid;
        n_b.zero   = r_a_zero;
        n_b.num[0] = {1'b0, px};
        n_b.num[1] = {1'b0, py};
        n_b.num[2] = {1'b0, pw} + {15'd0, i_dims.cc} - 29'd1;
        n_b.num[3] = {1'b0, ph} + {15'd0, i_dims.cr} - 29'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b.valid <= n_b.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b.zero <= n_b.zero;
            r_b.num  <= n_b.num;
        end
    end

    assign o_prod = r_b;

endmodule
`default_nettype wire

FILE: sv/ucs_div.sv
`default_nettype none
module ucs_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire ucs_pkg::t_prod i_prod,
    input  wire ucs_pkg::t_dims i_dims,
    output ucs_pkg::t_quo       o_quo
);

    localparam int unsigned PW = ucs_pkg::PW;
    localparam int unsigned LANES = ucs_pkg::LANES;

    ucs_pkg::t_div_st r_st [PW];
    ucs_pkg::t_div_st n_st [PW];

    for (genvar k = 0; k < PW; k++) begin : g_stage
        ucs_pkg::t_div_st prev;
        logic [LANES-1:0][14:0] trial;
        logic [LANES-1:0][13:0] dv;
        logic [LANES-1:0]       ge;

        always_comb begin
            if (k == 0) begin
                prev.valid = i_prod.valid;
                prev.zero  = i_prod.zero;
                prev.rem   = '0;
                prev.num   = i_prod.num;
                prev.quo   = '0;
            end else begin
                prev = r_st[(k == 0) ? 0 : k-1];
            end
            dv[0] = i_dims.cc;
            dv[1] = i_dims.cr;
            dv[2] = i_dims.cc;
            dv[3] = i_dims.cr;
            n_st[k].valid = prev.valid;
            n_st[k].zero  = prev.zero;
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {prev.rem[l], prev.num[l][PW-1]};
                ge[l]    = trial[l] >= {1'b0, dv[l]};
                n_st[k].rem[l] = ge[l] ? 14'(trial[l] - {1'b0, dv[l]}) : trial[l][13:0];
                n_st[k].num[l] = {prev.num[l][PW-2:0], 1'b0};
                n_st[k].quo[l] = {prev.quo[l][PW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k].valid <= n_st[k].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k].zero <= n_st[k].zero;
                r_st[k].rem  <= n_st[k].rem;
                r_st[k].num  <= n_st[k].num;
                r_st[k].quo  <= n_st[k].quo;
            end
        end
    end

    assign o_quo.valid = r_st[PW-1].valid;
    assign o_quo.zero  = r_st[PW-1].zero;
    assign o_quo.quo   = r_st[PW-1].quo;

endmodule
`default_nettype wire

FILE: sv/ucs_back.sv
`default_nettype none
module ucs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire ucs_pkg::t_quo  i_quo,
    input  wire ucs_pkg::t_dims i_dims,
    output logic                o_valid,
    output ucs_pkg::t_out_item  o_item
);

    localparam int unsigned PW = ucs_pkg::PW;

    logic          r_c_valid, r_c_zero;
    logic [PW-1:0] r_c_x, r_c_y, n_c_x, n_c_y;
    logic [PW:0]   r_c_w, r_c_h, n_c_w, n_c_h;

    logic                  r_valid;
    ucs_pkg::t_out_item    r_item, n_item;
    logic [PW+1:0]         sum_x, sum_y;
    logic signed [PW+1:0]  wf, hf;

    always_comb begin
        n_c_x = i_quo.quo[0];
        n_c_y = i_quo.quo[1];
        n_c_w = {1'b0, i_quo.quo[2]};
        n_c_h = {1'b0, i_quo.quo[3]};
        if (n_c_x[0]) begin
            n_c_x[0] = 1'b0;
            n_c_w    = n_c_w + (PW+1)'(1);
        end
        if (n_c_y[0]) begin
            n_c_y[0] = 1'b0;
            n_c_h    = n_c_h + (PW+1)'(1);
        end
        if (n_c_w[0]) n_c_w = n_c_w + (PW+1)'(1);
        if (n_c_h[0]) n_c_h = n_c_h + (PW+1)'(1);
        if (i_dims.scaled) begin
            if (n_c_x != '0) begin
                n_c_x = n_c_x - PW'(2);
                n_c_w = n_c_w + (PW+1)'(2);
            end
            if (n_c_y != '0) begin
                n_c_y = n_c_y - PW'(2);
                n_c_h = n_c_h + (PW+1)'(2);
            end
            n_c_w = n_c_w + (PW+1)'(2);
            n_c_h = n_c_h + (PW+1)'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_quo.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_zero <= i_quo.zero;
            r_c_x    <= n_c_x;
            r_c_y    <= n_c_y;
            r_c_w    <= n_c_w;
            r_c_h    <= n_c_h;
        end
    end

    always_comb begin
        sum_x = {2'b0, r_c_x} + {1'b0, r_c_w};
        sum_y = {2'b0, r_c_y} + {1'b0, r_c_h};
        if (sum_x > {(PW-12)'(0), i_dims.sw}) begin
            wf = $signed({(PW-12)'(0), i_dims.sw}) - $signed({2'b0, r_c_x});
        end else begin
            wf = $signed({1'b0, r_c_w});
        end
        if (sum_y > {(PW-12)'(0), i_dims.sh}) begin
            hf = $signed({(PW-12)'(0), i_dims.sh}) - $signed({2'b0, r_c_y});
        end else begin
            hf = $signed({1'b0, r_c_h});
        end
        if (r_c_zero || wf[PW+1] || (wf == '0) || hf[PW+1] || (hf == '0)) begin
            n_item = '0;
        end else begin
            n_item.out_left   = r_c_x[13:0];
            n_item.out_top    = r_c_y[13:0];
            n_item.out_width  = wf[13:0];
            n_item.out_height = hf[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

FILE: sv/update_rect_crop_scale_unit.sv
// Channel  | Valid    | Stall    | Payload
// ---------+----------+----------+-----------------------------
// in       | i_valid  | o_stall  | i_item (ucs_pkg::t_in_item)
// out      | o_valid  | i_stall  | o_item (ucs_pkg::t_out_item)
//
// One item enters every cycle unless the output stalls; each item passes through these stages:
// clip and multiply (2), a restoring divider at one quotient bit per stage (29),
// align and clamp (2). The divider stage count sets the latency.
// Reset clears all valid bits and loads register defaults.
// A stall while an output is valid freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module update_rect_crop_scale_unit #(
    parameter int unsigned MAX_DIM = ucs_pkg::MAX_DIM_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire ucs_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output ucs_pkg::t_out_item     o_item,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_addr,
    input  wire logic [13:0]       i_cfg_wr_data
);

    logic [12:0] r_crop_left, r_crop_top;
    logic [13:0] r_crop_cols, r_crop_rows, r_out_cols, r_out_rows;
    ucs_pkg::t_dims dims;
    ucs_pkg::t_prod prod;
    ucs_pkg::t_quo  quo;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crop_left <= 13'd0;
            r_crop_top  <= 13'd0;
            r_crop_cols <= 14'd1;
            r_crop_rows <= 14'd1;
            r_out_cols  <= 14'd1;
            r_out_rows  <= 14'd1;
        end else if (i_cfg_wr_en) begin
            unique case (ucs_pkg::t_cfg_idx'(i_cfg_addr))
                ucs_pkg::CFG_CROP_LEFT: r_crop_left <= i_cfg_wr_data[12:0];
                ucs_pkg::CFG_CROP_TOP:  r_crop_top  <= i_cfg_wr_data[12:0];
                ucs_pkg::CFG_CROP_COLS: r_crop_cols <= i_cfg_wr_data;
                ucs_pkg::CFG_CROP_ROWS: r_crop_rows <= i_cfg_wr_data;
                ucs_pkg::CFG_OUT_COLS:  r_out_cols  <= i_cfg_wr_data;
                ucs_pkg::CFG_OUT_ROWS:  r_out_rows  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        dims.cl = r_crop_left;
        dims.ct = r_crop_top;
        dims.cc = r_crop_cols;
        dims.cr = r_crop_rows;
        dims.sw = ({18'd0, r_out_cols} > 32'(MAX_DIM)) ? 14'(MAX_DIM) : r_out_cols;
        dims.sh = ({18'd0, r_out_rows} > 32'(MAX_DIM)) ? 14'(MAX_DIM) : r_out_rows;
        dims.scaled = (dims.sw != dims.cc) || (dims.sh != dims.cr);
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    ucs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_dims  (dims),
        .o_prod  (prod)
    );

    ucs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_prod  (prod),
        .i_dims  (dims),
        .o_quo   (quo)
    );

    ucs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_quo   (quo),
        .i_dims  (dims),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

FILE: sim/update_rect_crop_scale_checker.sv
`timescale 1ns / 100ps
module update_rect_crop_scale_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_stall_in,
    input  wire ucs_pkg::t_in_item  i_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire ucs_pkg::t_out_item i_out_item,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [13:0]        i_cfg_wr_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [12:0] crop_left, crop_top;
    logic [13:0] crop_cols, crop_rows, scaled_cols, scaled_rows;
    ucs_pkg::t_out_item scaled_rects[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch %s at %0t", msg, $realtime);
        o_fail_count++;
    endtask

    function automatic ucs_pkg::t_out_item scale_rect(input ucs_pkg::t_in_item r);
        longint rl, rt, rc, rr, cl, ct, cc, cr, sw, sh, x, y, w, h, cap;
        ucs_pkg::t_out_item o;
        cap = ucs_pkg::MAX_DIM_DEF;
        rl = r.rect_left; rt = r.rect_top; rc = r.rect_cols; rr = r.rect_rows;
        cl = crop_left; ct = crop_top; cc = crop_cols; cr = crop_rows;
        sw = (scaled_cols > cap) ? cap : scaled_cols;
        sh = (scaled_rows > cap) ? cap : scaled_rows;
        o = '0;
        if (cc == 0 || cr == 0 || rl + rc < cl || rl > cl + cc ||
            rt + rr < ct || rt > ct + cr) begin
            return o;
        end
        x = rl - cl; w = rc;
        if (x < 0) begin w += x; x = 0; end
        y = rt - ct; h = rr;
        if (y < 0) begin h += y; y = 0; end
        x = (x * sw) / cc;
        y = (y * sh) / cr;
        w = (w * sw + cc - 1) / cc;
        h = (h * sh + cr - 1) / cr;
        if (x[0]) begin x--; w++; end
        if (y[0]) begin y--; h++; end
        if (w[0]) w++;
        if (h[0]) h++;
        if (sw != cc || sh != cr) begin
            if (x > 0) begin x -= 2; w += 2; end
            if (y > 0) begin y -= 2; h += 2; end
            w += 2;
            h += 2;
        end
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w <= 0 || h <= 0) return o;
        o.out_left = x[13:0];
        o.out_top = y[13:0];
        o.out_width = w[13:0];
        o.out_height = h[13:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        ucs_pkg::t_out_item want;
        if (!i_rst_n) begin
            crop_left <= '0;
            crop_top <= '0;
            crop_cols <= 14'd1;
            crop_rows <= 14'd1;
            scaled_cols <= 14'd1;
            scaled_rows <= 14'd1;
        end else begin
            if (i_cfg_wr_en) begin
                case (ucs_pkg::t_cfg_idx'(i_cfg_addr))
                    ucs_pkg::CFG_CROP_LEFT: crop_left <= i_cfg_wr_data[12:0];
                    ucs_pkg::CFG_CROP_TOP:  crop_top <= i_cfg_wr_data[12:0];
                    ucs_pkg::CFG_CROP_COLS: crop_cols <= i_cfg_wr_data;
                    ucs_pkg::CFG_CROP_ROWS: crop_rows <= i_cfg_wr_data;
                    ucs_pkg::CFG_OUT_COLS:  scaled_cols <= i_cfg_wr_data;
                    ucs_pkg::CFG_OUT_ROWS:  scaled_rows <= i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) scaled_rects.push_back(scale_rect(i_item));
            if (i_out_valid && !i_out_stall) begin
                if (scaled_rects.size() == 0) begin
                    report_mismatch("unexpected item");
                end else begin
                    want = scaled_rects.pop_front();
                    if (i_out_item.out_left != want.out_left)
                        report_mismatch($sformatf("out_left: got %0d want %0d",
                                        i_out_item.out_left, want.out_left));
                    if (i_out_item.out_top != want.out_top)
                        report_mismatch($sformatf("out_top: got %0d want %0d",
                                        i_out_item.out_top, want.out_top));
                    if (i_out_item.out_width != want.out_width)
                        report_mismatch($sformatf("out_width: got %0d want %0d",
                                        i_out_item.out_width, want.out_width));
                    if (i_out_item.out_height != want.out_height)
                        report_mismatch($sformatf("out_height: got %0d want %0d",
                                        i_out_item.out_height, want.out_height));
                end
            end
        end
        o_pending = scaled_rects.size();
    end
endmodule

FILE: sim/update_rect_crop_scale_unit_tb.sv
`timescale 1ns / 100ps
module update_rect_crop_scale_unit_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    ucs_pkg::t_in_item  in_rect = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    ucs_pkg::t_out_item out_rect;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [13:0] cfg_wr_data = '0;
    int          fail_count, pending;
    int          send_idle_pct = 0, recv_idle_pct = 0;

    always #6 clk = ~clk;

    update_rect_crop_scale_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_item(in_rect),
        .o_valid(out_valid), .i_stall(out_stall), .o_item(out_rect),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_wr_data)
    );

    update_rect_crop_scale_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_item(in_rect),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_rect),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_addr(cfg_addr), .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [13:0] pick_dim(input int span);
        case ($urandom_range(9))
            0: return 14'(span);
            1: return 14'($urandom_range(8));
            2: return 14'($urandom_range(8192));
            default: return 14'($urandom_range(span < 1 ? 1 : span));
        endcase
    endfunction

    task automatic write_reg(input ucs_pkg::t_cfg_idx idx, input logic [13:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
    endtask

    task automatic send_rect(input ucs_pkg::t_in_item r);
        while (($urandom_range(99) < send_idle_pct)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_rect <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_crop(input logic [12:0] cl, input logic [12:0] ct,
                             input logic [13:0] cc, input logic [13:0] cr,
                             input logic [13:0] sw, input logic [13:0] sh);
        write_reg(ucs_pkg::CFG_CROP_LEFT, {1'b0, cl});
        write_reg(ucs_pkg::CFG_CROP_TOP, {1'b0, ct});
        write_reg(ucs_pkg::CFG_CROP_COLS, cc);
        write_reg(ucs_pkg::CFG_CROP_ROWS, cr);
        write_reg(ucs_pkg::CFG_OUT_COLS, sw);
        write_reg(ucs_pkg::CFG_OUT_ROWS, sh);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int cl, input int ct,
                                input int cc, input int cr);
        ucs_pkg::t_in_item r;
        repeat (count) begin
            if ($urandom_range(9) < 8) begin
                r.rect_left = 13'(cl - 20 + $urandom_range(cc + 40));
                r.rect_top = 13'(ct - 20 + $urandom_range(cr + 40));
            end else begin
                r.rect_left = 13'($urandom);
                r.rect_top = 13'($urandom);
            end
            r.rect_cols = pick_dim(cc);
            r.rect_rows = pick_dim(cr);
            send_rect(r);
        end
    endtask

    initial begin
        logic [12:0] cl, ct;
        logic [13:0] cc, cr, sw, sh;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_rect('{13'd0, 13'd0, 14'd1, 14'd1});
        send_rect('{13'd5, 13'd0, 14'd1, 14'd1});
        drain_results();
        load_crop(13'd100, 13'd50, 14'd640, 14'd480, 14'd320, 14'd240);
        send_rect('{13'd0, 13'd0, 14'd50, 14'd20});
        send_rect('{13'd800, 13'd60, 14'd10, 14'd10});
        send_rect('{13'd110, 13'd600, 14'd10, 14'd10});
        send_rect('{13'd101, 13'd51, 14'd3, 14'd3});
        send_rect('{13'd100, 13'd50, 14'd640, 14'd480});
        send_rect('{13'd740, 13'd530, 14'd8192, 14'd8192});
        send_rect('{13'd8191, 13'd8191, 14'd8192, 14'd8192});
        send_rect('{13'd90, 13'd40, 14'd0, 14'd0});
        send_rect('{13'd120, 13'd70, 14'd0, 14'd5});
        drain_results();
        load_crop(13'd0, 13'd0, 14'd0, 14'd10, 14'd16383, 14'd16383);
        send_rect('{13'd0, 13'd0, 14'd4, 14'd4});
        drain_results();
        load_crop(13'd8191, 13'd8191, 14'd8192, 14'd8192, 14'd16383, 14'd9000);
        send_rect('{13'd8191, 13'd8191, 14'd1, 14'd1});
        send_rect('{13'd0, 13'd0, 14'd8192, 14'd8192});
        drain_results();
        load_crop(13'd0, 13'd0, 14'd8192, 14'd8192, 14'd8192, 14'd8192);
        send_rect('{13'd7, 13'd9, 14'd3, 14'd5});
        send_rect('{13'd8191, 13'd8191, 14'd8192, 14'd8192});
        drain_results();

        for (int ph = 0; ph < 18; ph++) begin
            send_idle_pct = (ph < 6) ? 19 : (ph < 12) ? 82 : 0;
            recv_idle_pct = (ph < 6) ? 82 : (ph < 12) ? 19 : 0;
            cl = 13'($urandom_range(ph % 3 == 0 ? 8191 : 200));
            ct = 13'($urandom_range(ph % 4 == 0 ? 8191 : 200));
            cc = (ph == 1) ? 14'd8192 : (ph == 2) ? 14'd1 : 14'($urandom_range(1, 2000));
            cr = (ph == 1) ? 14'd8192 : (ph == 2) ? 14'd1 : 14'($urandom_range(1, 2000));
            case (ph % 4)
                0: begin sw = cc; sh = cr; end
                1: begin sw = 14'($urandom); sh = 14'($urandom); end
                default: begin
                    sw = 14'($urandom_range(1, 4000));
                    sh = 14'($urandom_range(1, 4000));
                end
            endcase
            if (ph == 7) begin cc = 14'd0; end
            load_crop(cl, ct, cc, cr, sw, sh);
            random_phase(100, cl, ct, cc, cr);
            drain_results();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
